/* hw/rtl/cocp_pkg.sv */
package cocp_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_AW    = 1;
   localparam int unsigned MUL_CHUNK   = 17;
   localparam int unsigned MUL_STEPS   = 4;
   localparam int unsigned DIV_STEPS   = 16;

   localparam logic [16:0] Q_ONE = 17'h10000;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TEST = 1'b1;

   typedef logic signed [31:0]  coord_type;
   typedef logic signed [32:0]  diff_type;
   typedef logic signed [67:0]  dot_type;
   typedef logic signed [135:0] prod_type;

   typedef struct packed {
      logic             kind;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] end_z;
      logic [30:0]      radius;
   } req_type;

   typedef struct packed {
      logic             hit;
      logic [62:0]      distance_sq;
      logic [16:0]      param_a;
      logic [16:0]      param_b;
      logic signed [31:0] closest_a_x;
      logic signed [31:0] closest_a_y;
      logic signed [31:0] closest_a_z;
      logic signed [31:0] closest_b_x;
      logic signed [31:0] closest_b_y;
      logic signed [31:0] closest_b_z;
   } rsp_type;

   typedef struct packed {
      coord_type [2:0] p1;
      coord_type [2:0] p2;
      diff_type [2:0]  d1;
      diff_type [2:0]  d2;
      diff_type [2:0]  r;
      logic [31:0]     rsum;
   } job_type;

   typedef struct packed {
      logic    go;
      dot_type op_a;
      dot_type op_b;
   } mul_req_type;

   typedef struct packed {
      logic     done;
      prod_type prod;
   } mul_rsp_type;

   typedef struct packed {
      logic     go;
      prod_type num;
      prod_type den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [16:0] quo;
   } div_rsp_type;

endpackage

/* hw/rtl/cocp_front.sv */
module cocp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  cocp_pkg::req_type req_data,
   output logic              req_full,
   input  logic              q_full,
   output logic              q_push,
   output cocp_pkg::job_type q_job
);
   import cocp_pkg::*;

   coord_type [2:0] ref_start_ff, ref_start_in;
   coord_type [2:0] ref_end_ff, ref_end_in;
   logic [30:0]     ref_radius_ff, ref_radius_in;
   coord_type [2:0] in_start;
   coord_type [2:0] in_end;
   logic            accept;

   assign in_start = {req_data.start_z, req_data.start_y, req_data.start_x};
   assign in_end   = {req_data.end_z, req_data.end_y, req_data.end_x};
   assign accept   = req_push && !q_full;
   assign req_full = q_full;
   assign q_push   = accept && (req_data.kind == KIND_TEST);

   always_comb begin
      ref_start_in  = ref_start_ff;
      ref_end_in    = ref_end_ff;
      ref_radius_in = ref_radius_ff;
      if (accept && (req_data.kind == KIND_LOAD)) begin
         ref_start_in  = in_start;
         ref_end_in    = in_end;
         ref_radius_in = req_data.radius;
      end
   end

   always_comb begin
      q_job.p1   = ref_start_ff;
      q_job.p2   = in_start;
      q_job.rsum = 32'(ref_radius_ff) + 32'(req_data.radius);
      for (int i = 0; i < 3; i++) begin
         q_job.d1[i] = 33'(signed'(ref_end_ff[i])) - 33'(signed'(ref_start_ff[i]));
         q_job.d2[i] = 33'(signed'(in_end[i])) - 33'(signed'(in_start[i]));
         q_job.r[i]  = 33'(signed'(ref_start_ff[i])) - 33'(signed'(in_start[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_start_ff  <= '0;
         ref_end_ff    <= '0;
         ref_radius_ff <= '0;
      end else begin
         ref_start_ff  <= ref_start_in;
         ref_end_ff    <= ref_end_in;
         ref_radius_ff <= ref_radius_in;
      end
   end

endmodule

/* hw/rtl/cocp_fifo.sv */
module cocp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cocp_pkg::job_type din,
   output logic              full,
   input  logic              pop,
   output cocp_pkg::job_type dout,
   output logic              empty
);
   import cocp_pkg::*;

   job_type               data_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full    = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(do_push);
      rd_ptr_in = rd_ptr_ff + QUEUE_AW'(do_pop);
      count_in  = count_ff + (QUEUE_AW + 1)'(do_push) - (QUEUE_AW + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

/* hw/rtl/cocp_mul.sv */
module cocp_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  cocp_pkg::mul_req_type req,
   output cocp_pkg::mul_rsp_type rsp
);
   import cocp_pkg::*;

   dot_type           a_ff, a_in;
   logic [67:0]       b_ff, b_in;
   prod_type          acc_ff, acc_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic signed [17:0] chunk;
   logic signed [85:0] pp;

   always_comb begin
      chunk = (cnt_ff == '0) ? {b_ff[67], b_ff[67 -: MUL_CHUNK]}
                             : {1'b0, b_ff[67 -: MUL_CHUNK]};
      pp    = 86'(a_ff) * 86'(chunk);
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.go) begin
         a_in    = req.op_a;
         b_in    = req.op_b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = (cnt_ff == '0) ? prod_type'(pp) : (acc_ff <<< MUL_CHUNK) + prod_type'(pp);
         b_in   = b_ff << MUL_CHUNK;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'(MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

endmodule

/* hw/rtl/cocp_div.sv */
module cocp_div (
   input  logic                  clock,
   input  logic                  reset,
   input  cocp_pkg::div_req_type req,
   output cocp_pkg::div_rsp_type rsp
);
   import cocp_pkg::*;

   typedef enum logic [2:0] {
      D_IDLE  = 3'b001,
      D_CHECK = 3'b010,
      D_RUN   = 3'b100
   } dstate_type;

   dstate_type          state_ff, state_in;
   logic signed [136:0] rem_ff, rem_in;
   logic signed [136:0] den_ff, den_in;
   logic signed [136:0] rem2;
   logic [16:0]         q_ff, q_in;
   logic [3:0]          cnt_ff, cnt_in;
   logic                done_ff, done_in;

   always_comb begin
      rem2     = rem_ff <<< 1;
      state_in = state_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         D_IDLE: begin
            if (req.go) begin
               rem_in   = 137'(req.num);
               den_in   = 137'(req.den);
               state_in = D_CHECK;
            end
         end
         D_CHECK: begin
            q_in   = '0;
            cnt_in = '0;
            if (rem_ff <= 0) begin
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else if (rem_ff >= den_ff) begin
               q_in     = Q_ONE;
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else begin
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            if (rem2 >= den_ff) begin
               rem_in = rem2 - den_ff;
               q_in   = {q_ff[15:0], 1'b1};
            end else begin
               rem_in = rem2;
               q_in   = {q_ff[15:0], 1'b0};
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(DIV_STEPS - 1)) begin
               done_in  = 1'b1;
               state_in = D_IDLE;
            end
         end
         default: state_in = D_IDLE;
      endcase
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

endmodule

/* hw/rtl/cocp_back.sv */
module cocp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [15:0]           thr,
   input  logic                  q_empty,
   input  cocp_pkg::job_type     q_job,
   output logic                  q_pop,
   output cocp_pkg::mul_req_type mul_req,
   input  cocp_pkg::mul_rsp_type mul_rsp,
   output cocp_pkg::div_req_type div_req,
   input  cocp_pkg::div_rsp_type div_rsp,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output cocp_pkg::rsp_type     rsp_data
);
   import cocp_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b000000000001,
      ST_DOT   = 12'b000000000010,
      ST_CLASS = 12'b000000000100,
      ST_DEN   = 12'b000000001000,
      ST_NUM   = 12'b000000010000,
      ST_TN    = 12'b000000100000,
      ST_FIX   = 12'b000001000000,
      ST_DIVW  = 12'b000010000000,
      ST_PTS   = 12'b000100000000,
      ST_DIST  = 12'b001000000000,
      ST_RSQ   = 12'b010000000000,
      ST_DONE  = 12'b100000000000
   } state_type;

   localparam logic [2:0] GRP_A = 3'd0;
   localparam logic [2:0] GRP_E = 3'd1;
   localparam logic [2:0] GRP_B = 3'd2;
   localparam logic [2:0] GRP_C = 3'd3;
   localparam logic [2:0] GRP_F = 3'd4;

   state_type       state_ff, state_in;
   job_type         job_ff, job_in;
   logic            waiting_ff, waiting_in;
   logic            idx_ff, idx_in;
   logic [2:0]      grp_ff, grp_in;
   logic [1:0]      comp_ff, comp_in;
   logic            side_ff, side_in;
   dot_type         acc_ff, acc_in;
   dot_type         a_ff, a_in, b_ff, b_in, c_ff, c_in, e_ff, e_in, f_ff, f_in;
   prod_type        tmp_ff, tmp_in, den_ff, den_in, tn_ff, tn_in;
   logic [16:0]     s_ff, s_in, t_ff, t_in;
   logic            dest_t_ff, dest_t_in;
   logic            ret_tn_ff, ret_tn_in;
   coord_type [2:0] c1_ff, c1_in, c2_ff, c2_in;
   dot_type         dist_ff, dist_in;
   logic [63:0]     rsq_ff, rsq_in;
   logic            mul_go_ff, mul_go_in;
   dot_type         mop_a_ff, mop_a_in, mop_b_ff, mop_b_in;
   logic            div_go_ff, div_go_in;
   prod_type        dnum_ff, dnum_in, dden_ff, dden_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   dot_type         opa, opb, vx, vy, sum, thr_x;
   prod_type        prod, prod_sh, td;
   diff_type        dd;
   logic            deg1, deg2, consume, out_free;

   assign prod    = mul_rsp.prod;
   assign consume = waiting_ff && mul_rsp.done;
   assign thr_x   = dot_type'({52'd0, thr});
   assign td      = prod_type'(e_ff) <<< 16;
   assign prod_sh = prod >>> 16;
   assign sum     = (comp_ff == '0) ? dot_type'(prod) : acc_ff + dot_type'(prod);
   assign deg1    = (a_ff <= thr_x);
   assign deg2    = (e_ff <= thr_x);
   assign out_free = !rsp_valid_ff || rsp_pop;
   assign q_pop   = (state_ff == ST_IDLE) && !q_empty;

   always_comb begin
      opa = '0;
      opb = '0;
      vx  = '0;
      vy  = '0;
      dd  = 33'(signed'(c1_ff[comp_ff])) - 33'(signed'(c2_ff[comp_ff]));
      case (grp_ff) inside
         GRP_E, GRP_F: vx = dot_type'(signed'(job_ff.d2[comp_ff]));
         default:      vx = dot_type'(signed'(job_ff.d1[comp_ff]));
      endcase
      case (grp_ff) inside
         GRP_A:        vy = dot_type'(signed'(job_ff.d1[comp_ff]));
         GRP_E, GRP_B: vy = dot_type'(signed'(job_ff.d2[comp_ff]));
         default:      vy = dot_type'(signed'(job_ff.r[comp_ff]));
      endcase
      unique case (state_ff)
         ST_DOT: begin
            opa = vx;
            opb = vy;
         end
         ST_DEN: begin
            opa = idx_ff ? (b_ff >>> 4) : (a_ff >>> 4);
            opb = idx_ff ? (b_ff >>> 4) : (e_ff >>> 4);
         end
         ST_NUM: begin
            opa = idx_ff ? (c_ff >>> 4) : (b_ff >>> 4);
            opb = idx_ff ? (e_ff >>> 4) : (f_ff >>> 4);
         end
         ST_TN: begin
            opa = b_ff;
            opb = dot_type'(s_ff);
         end
         ST_PTS: begin
            opa = side_ff ? dot_type'(signed'(job_ff.d2[comp_ff]))
                          : dot_type'(signed'(job_ff.d1[comp_ff]));
            opb = side_ff ? dot_type'(t_ff) : dot_type'(s_ff);
         end
         ST_DIST: begin
            opa = dot_type'(dd);
            opb = dot_type'(dd);
         end
         ST_RSQ: begin
            opa = dot_type'(job_ff.rsum);
            opb = dot_type'(job_ff.rsum);
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      waiting_in   = waiting_ff;
      idx_in       = idx_ff;
      grp_in       = grp_ff;
      comp_in      = comp_ff;
      side_in      = side_ff;
      acc_in       = acc_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      e_in         = e_ff;
      f_in         = f_ff;
      tmp_in       = tmp_ff;
      den_in       = den_ff;
      tn_in        = tn_ff;
      s_in         = s_ff;
      t_in         = t_ff;
      dest_t_in    = dest_t_ff;
      ret_tn_in    = ret_tn_ff;
      c1_in        = c1_ff;
      c2_in        = c2_ff;
      dist_in      = dist_ff;
      rsq_in       = rsq_ff;
      mul_go_in    = 1'b0;
      mop_a_in     = mop_a_ff;
      mop_b_in     = mop_b_ff;
      div_go_in    = 1'b0;
      dnum_in      = dnum_ff;
      dden_in      = dden_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;

      if (!waiting_ff && (state_ff == ST_DOT || state_ff == ST_DEN || state_ff == ST_TN ||
                          state_ff == ST_PTS || state_ff == ST_DIST || state_ff == ST_RSQ ||
                          (state_ff == ST_NUM && !(idx_ff == 1'b0 &&
                                                   (den_ff[135] || den_ff == '0))))) begin
         mul_go_in  = 1'b1;
         mop_a_in   = opa;
         mop_b_in   = opb;
         waiting_in = 1'b1;
      end
      if (consume) begin
         waiting_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               job_in   = q_job;
               grp_in   = GRP_A;
               comp_in  = '0;
               state_in = ST_DOT;
            end
         end
         ST_DOT: begin
            if (consume) begin
               acc_in = sum;
               if (comp_ff == 2'd2) begin
                  comp_in = '0;
                  grp_in  = grp_ff + 3'd1;
                  case (grp_ff)
                     GRP_A:   a_in = sum;
                     GRP_E:   e_in = sum;
                     GRP_B:   b_in = sum;
                     GRP_C:   c_in = sum;
                     default: f_in = sum;
                  endcase
                  if (grp_ff == GRP_F) begin
                     state_in = ST_CLASS;
                  end
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end
         end
         ST_CLASS: begin
            comp_in   = '0;
            side_in   = 1'b0;
            idx_in    = 1'b0;
            ret_tn_in = 1'b0;
            if (deg1 && deg2) begin
               s_in     = '0;
               t_in     = '0;
               state_in = ST_PTS;
            end else if (deg1) begin
               s_in      = '0;
               dnum_in   = prod_type'(f_ff);
               dden_in   = prod_type'(e_ff);
               dest_t_in = 1'b1;
               div_go_in = 1'b1;
               state_in  = ST_DIVW;
            end else if (deg2) begin
               t_in      = '0;
               dnum_in   = -prod_type'(c_ff);
               dden_in   = prod_type'(a_ff);
               dest_t_in = 1'b0;
               div_go_in = 1'b1;
               state_in  = ST_DIVW;
            end else begin
               state_in = ST_DEN;
            end
         end
         ST_DEN: begin
            if (consume) begin
               if (!idx_ff) begin
                  tmp_in = prod;
                  idx_in = 1'b1;
               end else begin
                  den_in   = tmp_ff - prod;
                  idx_in   = 1'b0;
                  state_in = ST_NUM;
               end
            end
         end
         ST_NUM: begin
            if (!waiting_ff && !idx_ff && (den_ff[135] || den_ff == '0)) begin
               s_in     = '0;
               state_in = ST_TN;
            end else if (consume) begin
               if (!idx_ff) begin
                  tmp_in = prod;
                  idx_in = 1'b1;
               end else begin
                  dnum_in   = tmp_ff - prod;
                  dden_in   = den_ff;
                  dest_t_in = 1'b0;
                  ret_tn_in = 1'b1;
                  div_go_in = 1'b1;
                  state_in  = ST_DIVW;
               end
            end
         end
         ST_TN: begin
            if (consume) begin
               tn_in    = prod + (prod_type'(f_ff) <<< 16);
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            ret_tn_in = 1'b0;
            div_go_in = 1'b1;
            state_in  = ST_DIVW;
            if (tn_ff[135]) begin
               t_in      = '0;
               dnum_in   = -prod_type'(c_ff);
               dden_in   = prod_type'(a_ff);
               dest_t_in = 1'b0;
            end else if (tn_ff > td) begin
               t_in      = Q_ONE;
               dnum_in   = prod_type'(b_ff) - prod_type'(c_ff);
               dden_in   = prod_type'(a_ff);
               dest_t_in = 1'b0;
            end else begin
               dnum_in   = tn_ff;
               dden_in   = td;
               dest_t_in = 1'b1;
            end
         end
         ST_DIVW: begin
            if (div_rsp.done) begin
               if (dest_t_ff) begin
                  t_in = div_rsp.quo;
               end else begin
                  s_in = div_rsp.quo;
               end
               comp_in  = '0;
               side_in  = 1'b0;
               state_in = ret_tn_ff ? ST_TN : ST_PTS;
            end
         end
         ST_PTS: begin
            if (consume) begin
               if (side_ff) begin
                  c2_in[comp_ff] = job_ff.p2[comp_ff] + prod_sh[31:0];
               end else begin
                  c1_in[comp_ff] = job_ff.p1[comp_ff] + prod_sh[31:0];
               end
               if (comp_ff == 2'd2) begin
                  comp_in = '0;
                  side_in = 1'b1;
                  if (side_ff) begin
                     state_in = ST_DIST;
                  end
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end
         end
         ST_DIST: begin
            if (consume) begin
               acc_in = sum;
               if (comp_ff == 2'd2) begin
                  dist_in  = sum;
                  comp_in  = '0;
                  state_in = ST_RSQ;
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end
         end
         ST_RSQ: begin
            if (consume) begin
               rsq_in   = prod[63:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.hit         = ($unsigned(dist_ff) <= {4'd0, rsq_ff});
               rsp_in.distance_sq = (dist_ff[67:63] != '0) ? '1 : dist_ff[62:0];
               rsp_in.param_a     = s_ff;
               rsp_in.param_b     = t_ff;
               rsp_in.closest_a_x = c1_ff[0];
               rsp_in.closest_a_y = c1_ff[1];
               rsp_in.closest_a_z = c1_ff[2];
               rsp_in.closest_b_x = c2_ff[0];
               rsp_in.closest_b_y = c2_ff[1];
               rsp_in.closest_b_z = c2_ff[2];
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign mul_req.go   = mul_go_ff;
   assign mul_req.op_a = mop_a_ff;
   assign mul_req.op_b = mop_b_ff;
   assign div_req.go   = div_go_ff;
   assign div_req.num  = dnum_ff;
   assign div_req.den  = dden_ff;
   assign rsp_empty    = !rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         waiting_ff   <= 1'b0;
         idx_ff       <= 1'b0;
         grp_ff       <= '0;
         comp_ff      <= '0;
         side_ff      <= 1'b0;
         mul_go_ff    <= 1'b0;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         waiting_ff   <= waiting_in;
         idx_ff       <= idx_in;
         grp_ff       <= grp_in;
         comp_ff      <= comp_in;
         side_ff      <= side_in;
         mul_go_ff    <= mul_go_in;
         div_go_ff    <= div_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      acc_ff    <= acc_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      e_ff      <= e_in;
      f_ff      <= f_in;
      tmp_ff    <= tmp_in;
      den_ff    <= den_in;
      tn_ff     <= tn_in;
      s_ff      <= s_in;
      t_ff      <= t_in;
      dest_t_ff <= dest_t_in;
      ret_tn_ff <= ret_tn_in;
      c1_ff     <= c1_in;
      c2_ff     <= c2_in;
      dist_ff   <= dist_in;
      rsq_ff    <= rsq_in;
      mop_a_ff  <= mop_a_in;
      mop_b_ff  <= mop_b_in;
      dnum_ff   <= dnum_in;
      dden_ff   <= dden_in;
      rsp_ff    <= rsp_in;
   end

   a_mul_div_excl: assert property (@(posedge clock) disable iff (reset)
      !(mul_go_ff && div_go_ff))
      else $error("multiplier and divider started together");

   a_mul_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> waiting_ff)
      else $error("product arrived with no request outstanding");

   a_param_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (s_ff <= Q_ONE && t_ff <= Q_ONE))
      else $error("segment parameter out of range");

   a_result_written: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> !rsp_empty)
      else $error("finished transaction did not reach the result register");

endmodule

/* hw/rtl/capsule_overlap_closest_points_unit.sv */
// A load transaction gives no result; test transactions go from the queue to the result
// register one at a time. The time is set by the shared 68 x 17 bit multiplier, used for
// 25 to 30 products, and by the 16-step divider used up to twice.
// Synchronous active-high reset clears the reference capsule to zero, the threshold to one
// and empties both queues.
module capsule_overlap_closest_points_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  cocp_pkg::req_type req_data,
   output logic              req_full,
   input  logic              rsp_pop,
   output cocp_pkg::rsp_type rsp_data,
   output logic              rsp_empty,
   input  logic              csr_valid,
   input  logic [15:0]       csr_data,
   output logic              csr_ready
);
   import cocp_pkg::*;

   localparam logic [15:0] THR_RESET = 16'd1;

   logic [15:0] thr_ff, thr_in;
   logic        q_full, q_push, q_pop, q_empty;
   job_type     q_in_job, q_out_job;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign csr_ready = 1'b1;
   assign thr_in    = (csr_valid && csr_ready) ? csr_data : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   cocp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_job    (q_in_job)
   );

   cocp_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_in_job),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_out_job),
      .empty (q_empty)
   );

   cocp_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   cocp_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   cocp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .thr       (thr_ff),
      .q_empty   (q_empty),
      .q_job     (q_out_job),
      .q_pop     (q_pop),
      .mul_req   (mul_req),
      .mul_rsp   (mul_rsp),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cocp_pkg::*;

   typedef logic signed [159:0] wide_type;

   localparam int STALL_LIMIT = 8000;
   localparam int HOLD_CYCLES = 600;
   localparam int SETTLE_CYCLES = 300;

   logic clock;
   logic reset;
   logic req_push;
   req_type req_data;
   logic req_full;
   logic rsp_pop;
   rsp_type rsp_data;
   logic rsp_empty;
   logic csr_valid;
   logic [15:0] csr_data;
   logic csr_ready;

   capsule_overlap_closest_points_unit dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_pop(rsp_pop), .rsp_data(rsp_data), .rsp_empty(rsp_empty),
      .csr_valid(csr_valid), .csr_data(csr_data), .csr_ready(csr_ready)
   );

   req_type pending_reqs[$];
   rsp_type awaited_results[$];
   int n_offered = 0;
   int n_taken = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int hold_left = 0;
   int holds_asked = 0;
   int holds_done = 0;
   int stall_count = 0;
   int mismatches = 0;
   bit quiet = 0;

   // Predictor copy of the block state.
   logic [15:0] threshold = 16'd1;
   coord_type ref_p [3];
   coord_type ref_q [3];
   logic [30:0] ref_rad;

   // Generator copy of the last reference capsule, used to build parallel segments.
   coord_type gen_p [3];
   coord_type gen_q [3];

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic logic [16:0] clamp_ratio(wide_type n, wide_type d);
      wide_type q;
      if (n <= 0) return 17'd0;
      if (n >= d) return Q_ONE;
      q = (n <<< 16) / d;
      return q[16:0];
   endfunction

   function automatic rsp_type predict_capsule_result(req_type t);
      rsp_type r;
      wide_type p1[3], p2[3], d1[3], d2[3], rv[3], c1[3], c2[3], dd;
      wide_type a, b, c, e, f, a4, b4, c4, e4, f4, den, tn, td, sw, tw, dist_acc, rs, sat;
      logic [16:0] s, tp;
      bit deg1, deg2;
      p2[0] = t.start_x; p2[1] = t.start_y; p2[2] = t.start_z;
      c1[0] = t.end_x; c1[1] = t.end_y; c1[2] = t.end_z;
      a = 0; b = 0; c = 0; e = 0; f = 0;
      for (int i = 0; i < 3; i++) begin
         p1[i] = ref_p[i];
         c2[i] = ref_q[i];
         d1[i] = c2[i] - p1[i];
         d2[i] = c1[i] - p2[i];
         rv[i] = p1[i] - p2[i];
         a = a + d1[i] * d1[i];
         e = e + d2[i] * d2[i];
         b = b + d1[i] * d2[i];
         c = c + d1[i] * rv[i];
         f = f + d2[i] * rv[i];
      end
      sw = threshold;
      deg1 = (a <= sw);
      deg2 = (e <= sw);
      s = 17'd0;
      tp = 17'd0;
      if (deg1 && !deg2) begin
         tp = clamp_ratio(f, e);
      end else if (!deg1 && deg2) begin
         s = clamp_ratio(-c, a);
      end else if (!deg1 && !deg2) begin
         a4 = a >>> 4; b4 = b >>> 4; c4 = c >>> 4; e4 = e >>> 4; f4 = f >>> 4;
         den = a4 * e4 - b4 * b4;
         if (den > 0) s = clamp_ratio(b4 * f4 - c4 * e4, den);
         sw = s;
         tn = b * sw + (f <<< 16);
         td = e <<< 16;
         if (tn < 0) begin
            tp = 17'd0;
            s = clamp_ratio(-c, a);
         end else if (tn > td) begin
            tp = Q_ONE;
            s = clamp_ratio(b - c, a);
         end else begin
            tp = clamp_ratio(tn, td);
         end
      end
      sw = s;
      tw = tp;
      dist_acc = 0;
      for (int i = 0; i < 3; i++) begin
         c1[i] = p1[i] + ((d1[i] * sw) >>> 16);
         c2[i] = p2[i] + ((d2[i] * tw) >>> 16);
         dd = c1[i] - c2[i];
         dist_acc = dist_acc + dd * dd;
      end
      rs = ref_rad;
      sw = t.radius;
      rs = rs + sw;
      sat = 1;
      sat = sat <<< 63;
      r.hit = (dist_acc <= rs * rs);
      r.distance_sq = (dist_acc >= sat) ? 63'h7FFF_FFFF_FFFF_FFFF : dist_acc[62:0];
      r.param_a = s;
      r.param_b = tp;
      r.closest_a_x = c1[0][31:0];
      r.closest_a_y = c1[1][31:0];
      r.closest_a_z = c1[2][31:0];
      r.closest_b_x = c2[0][31:0];
      r.closest_b_y = c2[1][31:0];
      r.closest_b_z = c2[2][31:0];
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endtask

   function automatic req_type capsule(logic kind, coord_type sx, coord_type sy,
                                       coord_type sz, coord_type ex, coord_type ey,
                                       coord_type ez, logic [30:0] rad);
      req_type t;
      t.kind = kind;
      t.start_x = sx; t.start_y = sy; t.start_z = sz;
      t.end_x = ex; t.end_y = ey; t.end_z = ez;
      t.radius = rad;
      return t;
   endfunction

   function automatic coord_type small_val(int bits);
      coord_type v;
      v = $urandom_range(0, (1 << bits) - 1);
      return v - (1 << (bits - 1));
   endfunction

   function automatic req_type random_capsule();
      req_type t;
      coord_type st[3], en[3];
      int bits, sc, ec;
      t.kind = ($urandom_range(0, 5) == 0) ? KIND_LOAD : KIND_TEST;
      sc = $urandom_range(0, 9);
      bits = $urandom_range(12, 21);
      ec = $urandom_range(0, 7);
      for (int i = 0; i < 3; i++) begin
         st[i] = (sc < 2) ? coord_type'($urandom) : small_val(bits);
         case (ec)
            0: en[i] = st[i];
            1: en[i] = st[i] + ((gen_q[i] - gen_p[i]) >>> $urandom_range(0, 3));
            2: en[i] = st[i] + small_val(2);
            3: en[i] = st[i] + small_val(9);
            default: en[i] = (sc < 2) ? coord_type'($urandom) : st[i] + small_val(bits);
         endcase
      end
      t.start_x = st[0]; t.start_y = st[1]; t.start_z = st[2];
      t.end_x = en[0]; t.end_y = en[1]; t.end_z = en[2];
      t.radius = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << bits));
      if (t.kind == KIND_LOAD) begin
         gen_p = st;
         gen_q = en;
      end
      return t;
   endfunction

   // Driver for the request side.
   always @(negedge clock) begin
      logic push_n;
      req_type data_n;
      push_n = req_push;
      data_n = req_data;
      if (reset) begin
         push_n = 1'b0;
      end else begin
         if (req_push && n_taken == n_offered) push_n = 1'b0;
         if (!push_n) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_reqs.size() > 0) begin
               data_n = pending_reqs.pop_front();
               push_n = 1'b1;
               n_offered++;
               if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 10);
            end
         end
      end
      req_push <= push_n;
      req_data <= data_n;
   end

   // Driver for the result side.
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (holds_done != holds_asked) begin
         holds_done++;
         hold_left = HOLD_CYCLES;
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
         if (!quiet && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 10);
      end
   end

   // Monitor, predictor and watchdog.
   always @(posedge clock) begin
      rsp_type want;
      bit progress;
      progress = 0;
      if (!reset) begin
         if (req_push && !req_full) begin
            n_taken++;
            progress = 1;
            if (req_data.kind == KIND_TEST) begin
               awaited_results.push_back(predict_capsule_result(req_data));
            end else begin
               ref_p[0] = req_data.start_x; ref_p[1] = req_data.start_y;
               ref_p[2] = req_data.start_z;
               ref_q[0] = req_data.end_x; ref_q[1] = req_data.end_y;
               ref_q[2] = req_data.end_z;
               ref_rad = req_data.radius;
            end
         end
         if (rsp_pop && !rsp_empty) begin
            progress = 1;
            if (awaited_results.size() == 0) begin
               $error("result transaction with no prediction waiting");
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               check_field("hit", want.hit, rsp_data.hit);
               check_field("distance_sq", want.distance_sq, rsp_data.distance_sq);
               check_field("param_a", want.param_a, rsp_data.param_a);
               check_field("param_b", want.param_b, rsp_data.param_b);
               check_field("closest_a_x", want.closest_a_x, rsp_data.closest_a_x);
               check_field("closest_a_y", want.closest_a_y, rsp_data.closest_a_y);
               check_field("closest_a_z", want.closest_a_z, rsp_data.closest_a_z);
               check_field("closest_b_x", want.closest_b_x, rsp_data.closest_b_x);
               check_field("closest_b_y", want.closest_b_y, rsp_data.closest_b_y);
               check_field("closest_b_z", want.closest_b_z, rsp_data.closest_b_z);
            end
         end
         if (csr_valid && csr_ready) begin
            threshold = csr_data;
            progress = 1;
         end
         if (progress || (pending_reqs.size() == 0 && n_offered == n_taken &&
                          awaited_results.size() == 0 && !csr_valid)) begin
            stall_count = 0;
         end else begin
            stall_count++;
            if (stall_count >= STALL_LIMIT) begin
               $display("end of test: mismatches");
               $finish;
            end
         end
      end
   end

   task automatic drain();
      while (pending_reqs.size() > 0 || n_offered != n_taken || awaited_results.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random(int count);
      repeat (count) pending_reqs.push_back(random_capsule());
   endtask

   localparam coord_type U = 32'sh0001_0000;
   localparam coord_type CMAX = 32'sh7FFF_FFFF;
   localparam coord_type CMIN = 32'sh8000_0000;
   localparam logic [30:0] RMAX = 31'h7FFF_FFFF;

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      ref_rad = '0;
      for (int i = 0; i < 3; i++) begin
         ref_p[i] = '0; ref_q[i] = '0; gen_p[i] = '0; gen_q[i] = 10 * U;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      pending_reqs.push_back(capsule(KIND_TEST, 0, 0, 0, U, 0, 0, U));
      pending_reqs.push_back(capsule(KIND_LOAD, 0, 0, 0, 10 * U, 0, 0, U));
      pending_reqs.push_back(capsule(KIND_TEST, 5 * U, -5 * U, U, 5 * U, 5 * U, U, 0));
      pending_reqs.push_back(capsule(KIND_TEST, 0, U, 0, 10 * U, U, 0, 0));
      pending_reqs.push_back(capsule(KIND_TEST, 12 * U, 0, 0, 20 * U, 0, 0, U));
      pending_reqs.push_back(capsule(KIND_TEST, -5 * U, 3 * U, 0, -5 * U, 9 * U, 0, 2 * U));
      pending_reqs.push_back(capsule(KIND_TEST, 3 * U, 2 * U, 0, 3 * U, 2 * U, 0, 2 * U));
      pending_reqs.push_back(capsule(KIND_TEST, 4 * U, U, 0, 4 * U + 1, U, 0, 0));
      pending_reqs.push_back(capsule(KIND_TEST, 14 * U, 3 * U, 0, 18 * U, -2 * U, U, RMAX));
      pending_reqs.push_back(capsule(KIND_LOAD, U, U, U, U, U, U, RMAX));
      pending_reqs.push_back(capsule(KIND_TEST, 0, 0, 0, 4 * U, 0, 0, 0));
      pending_reqs.push_back(capsule(KIND_TEST, 2 * U, 0, 0, 2 * U, 0, 0, U));
      pending_reqs.push_back(capsule(KIND_LOAD, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, RMAX));
      pending_reqs.push_back(capsule(KIND_TEST, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, RMAX));
      pending_reqs.push_back(capsule(KIND_TEST, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, RMAX));
      pending_reqs.push_back(capsule(KIND_TEST, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(capsule(KIND_TEST, CMAX, CMIN, 0, CMAX, CMIN, 0, 0));
      pending_reqs.push_back(capsule(KIND_LOAD, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0));
      pending_reqs.push_back(capsule(KIND_TEST, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 0));
      pending_reqs.push_back(capsule(KIND_LOAD, 0, 0, 0, 10 * U, 0, 0, U));
      queue_random(280);
      drain();

      // The receiver holds off while the sender keeps offering, so the block backs up.
      write_threshold(16'd0);
      holds_asked++;
      queue_random(250);
      drain();

      write_threshold(16'hFFFF);
      queue_random(250);
      drain();

      write_threshold(16'($urandom));
      queue_random(200);
      drain();

      write_threshold(16'd1);
      quiet = 1;
      queue_random(150);
      drain();

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
